// ----- rtl/mivu_pkg.sv -----
// Shared codes, types and defaults for the mesh IV index update block.
// No dependencies; used by every module of the block.
`default_nettype none
package mivu_pkg;

  // event kinds carried in in_tuser
  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_BEGIN  = 3'd1;
  localparam logic [2:0] ACT_FINISH = 3'd2;
  localparam logic [2:0] ACT_ARM    = 3'd3;
  localparam logic [2:0] ACT_BEACON = 3'd4;
  localparam logic [2:0] ACT_CHECK  = 3'd5;

  // result status carried in out_tuser
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_REJECT    = 3'd1;
  localparam logic [2:0] ST_NO_CHANGE = 3'd2;
  localparam logic [2:0] ST_STARTED   = 3'd3;
  localparam logic [2:0] ST_COMPLETED = 3'd4;
  localparam logic [2:0] ST_JUMPED    = 3'd5;

  // configuration register indexes
  localparam int         CFG_IDX_W = 1;
  localparam logic [0:0] CFG_DWELL = 1'b0;
  localparam logic [0:0] CFG_LOOK  = 1'b1;

  localparam logic [31:0] DWELL_RST = 32'd345600;
  localparam logic [31:0] LOOK_RST  = 32'd42;
  localparam logic [31:0] IDX_MAX   = 32'hFFFF_FFFF;

  localparam int TIME_BITS_DEF = 48;
  localparam int Q_DEPTH_DEF   = 4;
  localparam int OUT_DW        = 72;

  // decoded event kind, one-hot; all zero for unused codes
  typedef struct packed {
    logic load;
    logic start;
    logic finish;
    logic arm;
    logic beacon;
    logic check;
  } op_t;

  localparam int OP_W = $bits(op_t);

endpackage
`default_nettype wire

// ----- rtl/mesh_iv_update_state_machine.sv -----
// Mesh IV index update state machine: one event in, one result out.
//
// in_*  : event words. in_tuser is the event kind (load, begin, complete,
//         arm recovery, beacon, rx check). in_tdata carries the IV value,
//         the beacon update flag and the event time in seconds.
// out_* : one result word per event. out_tuser is the status; out_tdata
//         carries the rx check result, the transmit index, the current
//         index and the state and recovery flags after the event.
// cfg_* : register writes (0 minimum dwell seconds, 1 maximum lookahead);
//         always ready, write only while no events are in flight.
//
// An event taken into the decode register moves on into the queue, and its
// result is valid once the back end's output register loads it. Throughput:
// one event per clock while out_tready stays high, set by the state update
// in the back end.
// Reset clears the index, state flags and entry time, restores the
// register defaults and empties the pipeline. When the receiver stalls,
// the result holds, the queue (Q_DEPTH words) and decode register fill,
// and in_tready drops only once all of them are occupied.
// Depends on mivu_pkg, mivu_front, mivu_queue, mivu_back.
`default_nettype none
module mesh_iv_update_state_machine #(
  parameter int TIME_BITS = mivu_pkg::TIME_BITS_DEF,
  parameter int Q_DEPTH   = mivu_pkg::Q_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [2:0] action
  input  wire logic [2:0]                          in_tuser,
  // [31:0] iv_value, [32] update_flag, [TIME_BITS+32:33] event_time, zero pad
  input  wire logic [((TIME_BITS+40)/8)*8-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] status
  output logic [2:0]                               out_tuser,
  // [0] rx_accepted, [32:1] tx_index, [64:33] current_index,
  // [65] update_in_progress, [66] recovery_armed, [71:67] zero
  output logic [mivu_pkg::OUT_DW-1:0]              out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mivu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [31:0]                         cfg_data
);
  import mivu_pkg::*;

  localparam int QW = OP_W + 33 + TIME_BITS;

  logic          f_valid, f_ready, q_valid, q_ready;
  logic [QW-1:0] f_word, q_word;
  logic          o_acc, o_prog, o_rec;
  logic [31:0]   o_tx, o_idx;

  mivu_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_iv     (in_tdata[31:0]),
    .in_flag   (in_tdata[32]),
    .in_time   (in_tdata[TIME_BITS+32:33]),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_word    (f_word)
  );

  mivu_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_word),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_word)
  );

  mivu_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_word     (q_word),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_acc    (o_acc),
    .out_tx     (o_tx),
    .out_idx    (o_idx),
    .out_prog   (o_prog),
    .out_rec    (o_rec)
  );

  assign out_tdata = {5'b0, o_rec, o_prog, o_idx, o_tx, o_acc};

endmodule
`default_nettype wire

// ----- rtl/mivu_front.sv -----
// Front end: takes input words, decodes the event kind and holds one word
// in a register until the queue takes it. Depends on mivu_pkg.
`default_nettype none
module mivu_front #(
  parameter int TIME_BITS = mivu_pkg::TIME_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [2:0]                       in_action,
  input  wire logic [31:0]                      in_iv,
  input  wire logic                             in_flag,
  input  wire logic [TIME_BITS-1:0]             in_time,
  output logic                                  f_valid,
  input  wire logic                             f_ready,
  output logic [mivu_pkg::OP_W+33+TIME_BITS-1:0] f_word
);
  import mivu_pkg::*;

  logic                               fv_r;
  logic [OP_W+33+TIME_BITS-1:0]       fw_r;
  op_t                                op_dec;

  always_comb begin
    op_dec = '0;
    unique case (in_action)
      ACT_LOAD:   op_dec.load   = 1'b1;
      ACT_BEGIN:  op_dec.start  = 1'b1;
      ACT_FINISH: op_dec.finish = 1'b1;
      ACT_ARM:    op_dec.arm    = 1'b1;
      ACT_BEACON: op_dec.beacon = 1'b1;
      ACT_CHECK:  op_dec.check  = 1'b1;
      default:    op_dec = '0;
    endcase
  end

  assign in_tready = !fv_r || f_ready;
  assign f_valid   = fv_r;
  assign f_word    = fw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tready) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      fw_r <= {op_dec, in_iv, in_flag, in_time};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mivu_queue.sv -----
// Small FIFO between the decode front end and the state back end.
// Depends on mivu_pkg for defaults only.
`default_nettype none
module mivu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mivu_pkg::Q_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mivu_back.sv -----
// Back end: IV index state, dwell timer test, beacon rules, config
// registers and the output register. Depends on mivu_pkg.
`default_nettype none
module mivu_back #(
  parameter int TIME_BITS = mivu_pkg::TIME_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [mivu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [31:0]                           cfg_data,
  input  wire logic                                  q_valid,
  output logic                                       q_ready,
  input  wire logic [mivu_pkg::OP_W+33+TIME_BITS-1:0] q_word,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [2:0]                                 out_status,
  output logic                                       out_acc,
  output logic [31:0]                                out_tx,
  output logic [31:0]                                out_idx,
  output logic                                       out_prog,
  output logic                                       out_rec
);
  import mivu_pkg::*;

  op_t                  op;
  logic [31:0]          iv;
  logic                 flag;
  logic [TIME_BITS-1:0] tm;

  logic [31:0]          dwell_r, look_r;
  logic [31:0]          idx_r, idx_nxt;
  logic                 prog_r, prog_nxt;
  logic [TIME_BITS-1:0] ent_r, ent_nxt;
  logic                 rec_r, rec_nxt;

  logic                 ov_r;
  logic [2:0]           st_r, st_nxt;
  logic                 acc_r, acc_nxt;
  logic [31:0]          tx_r, tx_nxt;
  logic [31:0]          oidx_r;
  logic                 oprog_r, orec_r;

  logic                 pop, dwell_ok;
  logic [31:0]          diff;

  assign {op, iv, flag, tm} = q_word;

  assign cfg_ready = 1'b1;
  assign q_ready   = !ov_r || out_tready;
  assign pop       = q_valid && q_ready;

  // a clock running backwards never satisfies the dwell
  assign dwell_ok = (tm >= ent_r) && ((tm - ent_r) >= TIME_BITS'(dwell_r));
  assign diff     = iv - idx_r;

  always_comb begin
    idx_nxt  = idx_r;
    prog_nxt = prog_r;
    ent_nxt  = ent_r;
    rec_nxt  = rec_r;
    st_nxt   = ST_REJECT;
    acc_nxt  = 1'b0;
    priority if (op.load) begin
      idx_nxt  = iv;
      prog_nxt = 1'b0;
      ent_nxt  = tm;
      rec_nxt  = 1'b0;
      st_nxt   = ST_OK;
    end else if (op.start) begin
      if (!prog_r && dwell_ok && idx_r != IDX_MAX) begin
        idx_nxt  = idx_r + 32'd1;
        prog_nxt = 1'b1;
        ent_nxt  = tm;
        st_nxt   = ST_STARTED;
      end
    end else if (op.finish) begin
      if (prog_r && dwell_ok) begin
        prog_nxt = 1'b0;
        ent_nxt  = tm;
        st_nxt   = ST_COMPLETED;
      end
    end else if (op.arm) begin
      rec_nxt = 1'b1;
      st_nxt  = ST_OK;
    end else if (op.beacon) begin
      if (iv < idx_r || diff > look_r) begin
        st_nxt = ST_REJECT;
      end else if (diff == 32'd0) begin
        if (!flag && prog_r && dwell_ok) begin
          prog_nxt = 1'b0;
          ent_nxt  = tm;
          st_nxt   = ST_COMPLETED;
        end else begin
          st_nxt = ST_NO_CHANGE;
        end
      end else if (diff == 32'd1 && !rec_r) begin
        if (!flag) begin
          st_nxt = ST_REJECT;
        end else if (prog_r || !dwell_ok) begin
          st_nxt = ST_NO_CHANGE;
        end else begin
          idx_nxt  = iv;
          prog_nxt = 1'b1;
          ent_nxt  = tm;
          st_nxt   = ST_STARTED;
        end
      end else if (rec_r) begin
        // recovery: adopt whatever the beacon says
        idx_nxt  = iv;
        prog_nxt = flag;
        ent_nxt  = tm;
        rec_nxt  = 1'b0;
        st_nxt   = ST_JUMPED;
      end else begin
        st_nxt = ST_REJECT;
      end
    end else if (op.check) begin
      acc_nxt = (iv == idx_r) || (idx_r != 32'd0 && iv == idx_r - 32'd1);
      st_nxt  = ST_OK;
    end
    tx_nxt = (prog_nxt && idx_nxt != 32'd0) ? idx_nxt - 32'd1 : idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DWELL_RST;
      look_r  <= LOOK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DWELL: dwell_r <= cfg_data;
        CFG_LOOK:  look_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      prog_r <= 1'b0;
      ent_r  <= '0;
      rec_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (pop) begin
        idx_r  <= idx_nxt;
        prog_r <= prog_nxt;
        ent_r  <= ent_nxt;
        rec_r  <= rec_nxt;
      end
      if (q_ready) begin
        ov_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st_r    <= st_nxt;
      acc_r   <= acc_nxt;
      tx_r    <= tx_nxt;
      oidx_r  <= idx_nxt;
      oprog_r <= prog_nxt;
      orec_r  <= rec_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_status = st_r;
  assign out_acc    = acc_r;
  assign out_tx     = tx_r;
  assign out_idx    = oidx_r;
  assign out_prog   = oprog_r;
  assign out_rec    = orec_r;

endmodule
`default_nettype wire

// ----- rtl/mivu_checker.sv -----
// Port-level checks for the mesh IV index update block, bound to the top.
// Depends on mivu_pkg and mesh_iv_update_state_machine.
`default_nettype none
module mivu_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [2:0]                  out_tuser,
  input wire logic [mivu_pkg::OUT_DW-1:0] out_tdata
);
  import mivu_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // rx acceptance only ever comes with an ok status
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tuser == ST_OK)
    else $error("rx accepted with non-ok status");

  // outside an update the transmit index is the current index
  a_tx_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[65] |-> out_tdata[32:1] == out_tdata[64:33])
    else $error("tx index differs from current index in Normal state");

  // started leaves the block in progress, completed leaves it in Normal
  a_state_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != ST_STARTED || out_tdata[65])
                && (out_tuser != ST_COMPLETED || !out_tdata[65]))
    else $error("status disagrees with reported state");

  // a jump always disarms recovery
  a_jump_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_JUMPED |-> !out_tdata[66])
    else $error("recovery still armed after jump");

endmodule

bind mesh_iv_update_state_machine mivu_checker u_mivu_checker (.*);
`default_nettype wire

// ----- tb/sv/iv_update_checker.sv -----
// Result checker for the mesh IV index update block: tracks the block's state
// from the event and register words it takes and compares every result word.
// Depends on mivu_pkg for codes, register indexes and reset defaults.
module iv_update_checker #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [2:0]                        in_tuser,
  input  logic [((TIME_BITS+40)/8)*8-1:0]   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [2:0]                        out_tuser,
  input  logic [mivu_pkg::OUT_DW-1:0]       out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [mivu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                fail_count,
  output int                                results_checked,
  output int                                outstanding
);
  import mivu_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        rx_ok;
    logic [31:0] tx_idx;
    logic [31:0] iv_idx;
    logic        in_prog;
    logic        rec_armed;
  } iv_result_t;

  // tracked block state and registers
  logic [31:0]          cur_idx;
  logic                 prog;
  logic [TIME_BITS-1:0] entered;
  logic                 armed;
  logic [31:0]          dwell_min;
  logic [31:0]          look_max;

  iv_result_t expected_results[$];
  iv_result_t want;

  // backwards clock never counts as elapsed
  function automatic logic dwell_met(logic [TIME_BITS-1:0] now);
    return (now >= entered) && ((now - entered) >= {{(TIME_BITS-32){1'b0}}, dwell_min});
  endfunction

  function automatic iv_result_t apply_iv_event(logic [2:0] act, logic [31:0] val, logic flg,
                                                logic [TIME_BITS-1:0] now);
    iv_result_t r;
    r = '0;
    r.status = ST_REJECT;
    case (act)
      ACT_LOAD: begin
        cur_idx = val;
        prog = 1'b0;
        entered = now;
        armed = 1'b0;
        r.status = ST_OK;
      end
      ACT_BEGIN: begin
        if (!prog && dwell_met(now) && cur_idx != IDX_MAX) begin
          cur_idx = cur_idx + 32'd1;
          prog = 1'b1;
          entered = now;
          r.status = ST_STARTED;
        end
      end
      ACT_FINISH: begin
        if (prog && dwell_met(now)) begin
          prog = 1'b0;
          entered = now;
          r.status = ST_COMPLETED;
        end
      end
      ACT_ARM: begin
        armed = 1'b1;
        r.status = ST_OK;
      end
      ACT_BEACON: begin
        if (val < cur_idx || (val - cur_idx) > look_max) begin
          r.status = ST_REJECT;
        end else if (val == cur_idx) begin
          if (!flg && prog && dwell_met(now)) begin
            prog = 1'b0;
            entered = now;
            r.status = ST_COMPLETED;
          end else begin
            r.status = ST_NO_CHANGE;
          end
        end else if (val == cur_idx + 32'd1 && !armed) begin
          if (!flg) begin
            r.status = ST_REJECT;
          end else if (prog || !dwell_met(now)) begin
            r.status = ST_NO_CHANGE;
          end else begin
            cur_idx = val;
            prog = 1'b1;
            entered = now;
            r.status = ST_STARTED;
          end
        end else if (armed) begin
          // recovery: take the beacon's index and state outright
          cur_idx = val;
          prog = flg;
          entered = now;
          armed = 1'b0;
          r.status = ST_JUMPED;
        end else begin
          r.status = ST_REJECT;
        end
      end
      ACT_CHECK: begin
        r.rx_ok = (val == cur_idx) || (cur_idx != 32'd0 && val == cur_idx - 32'd1);
        r.status = ST_OK;
      end
      default: begin
      end
    endcase
    r.tx_idx = (prog && cur_idx != 32'd0) ? cur_idx - 32'd1 : cur_idx;
    r.iv_idx = cur_idx;
    r.in_prog = prog;
    r.rec_armed = armed;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_idx = '0;
      prog = 1'b0;
      entered = '0;
      armed = 1'b0;
      dwell_min = DWELL_RST;
      look_max = LOOK_RST;
      expected_results.delete();
    end else begin
      // drain before push: a result word always belongs to an older event
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t  unexpected result word: expected none, actual status %0d data %0h",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("rx_accepted", 32'(want.rx_ok), 32'(out_tdata[0]));
          check_field("tx_index", want.tx_idx, out_tdata[32:1]);
          check_field("current_index", want.iv_idx, out_tdata[64:33]);
          check_field("update_in_progress", 32'(want.in_prog), 32'(out_tdata[65]));
          check_field("recovery_armed", 32'(want.rec_armed), 32'(out_tdata[66]));
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DWELL: dwell_min = cfg_data;
          CFG_LOOK:  look_max = cfg_data;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_iv_event(in_tuser, in_tdata[31:0], in_tdata[32],
                                                  in_tdata[TIME_BITS+32:33]));
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the mesh IV index update testbench: clock, reset, event and register
// stimulus, output back-pressure and the verdict.
// Depends on mivu_pkg, mesh_iv_update_state_machine and iv_update_checker.
module tb_top;
  import mivu_pkg::*;

  localparam int TIME_BITS = 48;
  localparam int IN_DW = ((TIME_BITS + 40) / 8) * 8;
  // codes the block does not define; they must come back rejected
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2:0]           in_tuser;
  logic [IN_DW-1:0]     in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [2:0]           out_tuser;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int fail_count;
  int results_checked;
  int outstanding;

  bit          choke_req;
  int          snd_free_left;
  logic [47:0] now_t;
  logic [31:0] idx_guess;
  logic [31:0] dwell_cur;
  logic [31:0] look_cur;
  int          events_sent;
  int          settings_used;

  mesh_iv_update_state_machine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  iv_update_checker #(.TIME_BITS(TIME_BITS)) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tuser       (out_tuser),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("timeout: result words still missing");
    $display("CHECKS FAILED");
    $finish;
  end

  // output back-pressure; a choke request holds tready low for a long stall
  initial begin
    int r;
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        stall_left = 60;
        free_left = 0;
      end else if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 12)
          free_left = $urandom_range(15, 50);
        else if (r >= 96)
          stall_left = $urandom_range(8, 30);
        else if (r >= 80)
          stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (free_left > 0) free_left--;
      end
      @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (snd_free_left > 0) begin
      snd_free_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      snd_free_left = $urandom_range(15, 50);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly steps around the dwell boundary, sometimes backwards or anywhere
  function automatic logic [47:0] step_time();
    int r;
    logic [63:0] w;
    r = $urandom_range(0, 99);
    if (r < 40)
      now_t = now_t + dwell_cur + $urandom_range(0, 3);
    else if (r < 52)
      now_t = now_t + dwell_cur - 48'd1;
    else if (r < 72)
      now_t = now_t + $urandom_range(0, 5);
    else if (r < 84)
      now_t = now_t + $urandom;
    else if (r < 92)
      now_t = now_t - $urandom_range(1, 1000);
    else begin
      w = {$urandom, $urandom};
      now_t = w[47:0];
    end
    return now_t;
  endfunction

  function automatic logic [31:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return IDX_MAX - $urandom_range(0, 2);
    if (r < 30) return idx_guess + $urandom_range(0, 3);
    return $urandom;
  endfunction

  task automatic send_event(input logic [2:0] act, input logic [31:0] val, input logic flg,
                            input logic [47:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {{(IN_DW-TIME_BITS-33){1'b0}}, t, flg, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sent++;
    // rough idea of the index, only used to aim the stimulus
    case (act)
      ACT_LOAD:   idx_guess = val;
      ACT_BEGIN:  if (idx_guess != IDX_MAX) idx_guess = idx_guess + 32'd1;
      ACT_BEACON: if (val > idx_guess && (val - idx_guess) <= look_cur) idx_guess = val;
      default: begin
      end
    endcase
  endtask

  // drop valid, then wait until every expected word has come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] dwell, input logic [31:0] look);
    wait_idle();
    cfg_valid <= 1'b1;
    for (int k = 0; k < 2; k++) begin
      cfg_index <= (k == 0) ? CFG_DWELL : CFG_LOOK;
      cfg_data <= (k == 0) ? dwell : look;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    dwell_cur = dwell;
    look_cur = look;
    settings_used++;
  endtask

  task automatic run_scenario();
    int sel;
    logic [31:0] off;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        // local update: load, begin, up to two rx checks, complete
        send_event(ACT_LOAD, pick_index(), 1'($urandom_range(0, 1)), step_time());
        send_event(ACT_BEGIN, $urandom, 1'($urandom_range(0, 1)), step_time());
        repeat ($urandom_range(0, 2))
          send_event(ACT_CHECK, idx_guess + $urandom_range(0, 3) - 32'd2,
                     1'($urandom_range(0, 1)), now_t);
        send_event(ACT_FINISH, $urandom, 1'($urandom_range(0, 1)), step_time());
      end
      2, 3: begin
        // beacon-driven update: next index, mostly with flag set, then same index, mostly with flag clear
        if ($urandom_range(0, 1))
          send_event(ACT_LOAD, pick_index(), 1'b0, step_time());
        send_event(ACT_BEACON, idx_guess + 32'd1, $urandom_range(0, 3) != 0, step_time());
        send_event(ACT_BEACON, idx_guess, $urandom_range(0, 3) == 0, step_time());
      end
      4, 5: begin
        // recovery jump, aimed at the lookahead edges part of the time
        case ($urandom_range(0, 5))
          0: off = look_cur;
          1: off = look_cur + 32'd1;
          2: off = 32'd0;
          3: off = 32'hFFFF_FFFF;
          default: off = $urandom_range(1, (look_cur > 60) ? 60 : look_cur);
        endcase
        if ($urandom_range(0, 4) != 0)
          send_event(ACT_ARM, $urandom, 1'($urandom_range(0, 1)), now_t);
        send_event(ACT_BEACON, idx_guess + off, 1'($urandom_range(0, 1)), step_time());
        send_event(ACT_CHECK, idx_guess - $urandom_range(0, 1), 1'b0, now_t);
      end
      6: begin
        repeat ($urandom_range(1, 3))
          send_event(ACT_CHECK, idx_guess + $urandom_range(0, 3) - 32'd2,
                     1'($urandom_range(0, 1)), step_time());
      end
      7: begin
        send_event(ACT_BEGIN, $urandom, 1'($urandom_range(0, 1)), step_time());
        send_event(ACT_FINISH, $urandom, 1'($urandom_range(0, 1)), step_time());
      end
      default: begin
        repeat ($urandom_range(1, 4))
          send_event(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)),
                     step_time());
      end
    endcase
  endtask

  initial begin
    int start;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    choke_req = 1'b0;
    snd_free_left = 0;
    now_t = '0;
    idx_guess = '0;
    dwell_cur = DWELL_RST;
    look_cur = LOOK_RST;
    events_sent = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases at the reset register values
    send_event(ACT_CHECK, 32'd0, 1'b0, 48'd0);
    send_event(ACT_BEGIN, 32'd0, 1'b0, 48'd345599);        // dwell one short
    send_event(ACT_BEACON, 32'd1, 1'b1, 48'd100);          // next index, dwell not met
    send_event(ACT_BEGIN, 32'd0, 1'b0, 48'd345600);        // starts, index 1
    send_event(ACT_CHECK, 32'd0, 1'b0, 48'd345600);        // previous index accepted
    send_event(ACT_FINISH, 32'd0, 1'b0, 48'd345601);       // too early
    send_event(ACT_BEACON, 32'd1, 1'b0, 48'd400000);       // same index, too early
    send_event(ACT_BEACON, 32'd1, 1'b0, 48'd691200);       // completes
    send_event(ACT_FINISH, 32'd0, 1'b0, 48'd2000000);      // wrong state
    send_event(ACT_BEACON, 32'd0, 1'b1, 48'd2000000);      // lower index
    send_event(ACT_BEACON, 32'd44, 1'b1, 48'd2000000);     // one past lookahead
    send_event(ACT_BEACON, 32'd2, 1'b0, 48'd2000000);      // next index, flag clear
    send_event(ACT_BEACON, 32'd2, 1'b1, 48'd2000000);      // beacon starts update
    send_event(ACT_BEACON, 32'd3, 1'b1, 48'd2000001);      // next while in progress
    send_event(ACT_BEACON, 32'd4, 1'b1, 48'd2000001);      // further ahead, not armed
    send_event(ACT_BEGIN, 32'd0, 1'b0, 48'd3000000);       // already in progress
    send_event(ACT_FINISH, 32'd0, 1'b0, 48'd100);          // clock ran backwards
    send_event(ACT_ARM, 32'd0, 1'b0, 48'd100);
    send_event(ACT_BEACON, 32'd44, 1'b1, 48'd100);         // jump to lookahead edge
    send_event(ACT_ARM, 32'd0, 1'b0, 48'd100);
    send_event(ACT_BEACON, 32'd45, 1'b0, 48'd100);         // armed next index jumps
    send_event(ACT_BEACON, 32'd45, 1'b1, 48'd100);         // same index, flag set
    send_event(ACT_LOAD, IDX_MAX, 1'b0, 48'd1000);
    send_event(ACT_BEGIN, 32'd0, 1'b0, 48'hFFFF_FFFF_FFFF); // index cannot advance
    send_event(ACT_CHECK, 32'hFFFF_FFFE, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_event(ACT_SPARE_LO, 32'h5A5A_5A5A, 1'b1, 48'd7);
    send_event(ACT_SPARE_HI, 32'hA5A5_A5A5, 1'b0, 48'd8);
    send_event(ACT_LOAD, 32'd0, 1'b1, 48'd0);
    now_t = '0;
    idx_guess = '0;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_regs(32'd20, 32'd42);
        1: set_regs(32'd0, 32'd0);
        2: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_regs(32'd3, 32'd5);
      endcase
      if (p == 0) begin
        // long output stall while events keep coming back to back
        choke_req = 1'b1;
        snd_free_left = 40;
      end
      start = events_sent;
      while (events_sent - start < 135) run_scenario();
    end

    wait_idle();
    $display("%0d events driven under %0d register settings, %0d result words checked",
             events_sent, settings_used, results_checked);
    $display("covered dwell and lookahead extremes, recovery jumps, backward clock, long stall");
    if (fail_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
